// ----- design/usbcs_pkg.sv -----
// Shared types, codes and configuration defaults for the USB control endpoint sequencer.
package usbcs_pkg;

	// Default depth of the result queue.
	localparam int unsigned OutDepthDefault = 4;

	// Input event kinds.
	localparam logic [1:0] KindSetup    = 2'd0;
	localparam logic [1:0] KindPoll     = 2'd1;
	localparam logic [1:0] KindInDone   = 2'd2;
	localparam logic [1:0] KindBusReset = 2'd3;

	// Result action codes.
	localparam logic [2:0] ActNone     = 3'd0;
	localparam logic [2:0] ActWrite    = 3'd1;
	localparam logic [2:0] ActSetAddr  = 3'd2;
	localparam logic [2:0] ActConfigEp = 3'd3;
	localparam logic [2:0] ActMouse    = 3'd4;

	// Descriptor source codes.
	localparam logic [1:0] SrcNone   = 2'd0;
	localparam logic [1:0] SrcDevice = 2'd1;
	localparam logic [1:0] SrcConfig = 2'd2;
	localparam logic [1:0] SrcHid    = 2'd3;

	// Device state codes.
	localparam logic [1:0] DevDefault    = 2'd0;
	localparam logic [1:0] DevAddressed  = 2'd1;
	localparam logic [1:0] DevConfigured = 2'd2;

	// Control stage codes as shown on the result port.
	localparam logic [2:0] StageSetupCode     = 3'd0;
	localparam logic [2:0] StageDataInCode    = 3'd1;
	localparam logic [2:0] StageIdleCode      = 3'd2;
	localparam logic [2:0] StageZeroCode      = 3'd3;
	localparam logic [2:0] StageStatusOutCode = 3'd4;
	localparam logic [2:0] StageStatusInCode  = 3'd5;

	// Setup request decoding.
	localparam logic [6:0] SelStdDevice = 7'h00;
	localparam logic [6:0] SelClassIntf = 7'h21;
	localparam logic [6:0] SelStdIntf   = 7'h01;
	localparam logic [7:0] ReqSetAddress    = 8'h05;
	localparam logic [7:0] ReqGetDescriptor = 8'h06;
	localparam logic [7:0] ReqSetConfig     = 8'h09;
	localparam logic [7:0] ReqSetIdle       = 8'h0A;
	localparam logic [7:0] DescDevice    = 8'h01;
	localparam logic [7:0] DescConfig    = 8'h02;
	localparam logic [7:0] DescHidReport = 8'h22;

	// Configuration register indexes.
	localparam logic [2:0] CfgEp0MaxPacket   = 3'd0;
	localparam logic [2:0] CfgDataEndpoint   = 3'd1;
	localparam logic [2:0] CfgDataEpType     = 3'd2;
	localparam logic [2:0] CfgDataEpMaxPkt   = 3'd3;
	localparam logic [2:0] CfgDeviceDescLen  = 3'd4;
	localparam logic [2:0] CfgConfigDescLen  = 3'd5;
	localparam logic [2:0] CfgHidReportLen   = 3'd6;
	localparam logic [2:0] CfgMouseReportLen = 3'd7;

	// Configuration register set.
	typedef struct packed {
		logic [6:0] ep0_max_packet;
		logic [3:0] data_endpoint;
		logic [1:0] data_ep_type;
		logic [9:0] data_ep_max_packet;
		logic [7:0] device_desc_len;
		logic [9:0] config_desc_len;
		logic [9:0] hid_report_len;
		logic [6:0] mouse_report_len;
	} cfg_t;

	// One input event.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  request_type;
		logic [7:0]  request_code;
		logic [15:0] request_value;
		logic [15:0] request_length;
		logic [3:0]  endpoint;
	} item_t;

	// One result.
	typedef struct packed {
		logic [2:0]  action;
		logic [3:0]  packet_endpoint;
		logic [1:0]  data_source;
		logic [15:0] data_offset;
		logic [9:0]  packet_length;
		logic [6:0]  new_address;
		logic [1:0]  ep_type;
		logic [1:0]  device_state;
		logic [2:0]  control_stage;
		logic        last;
	} result_t;

endpackage

// ----- design/usbcs_cfg_regs.sv -----
// Configuration register file of the USB control endpoint sequencer.
module usbcs_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [2:0]          wr_index,
	input  logic [9:0]          wr_data,
	output usbcs_pkg::cfg_t     cfg
);

	usbcs_pkg::cfg_t cfg_q;

	// Registers load their reset values and take one write per transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ep0_max_packet     <= 7'd64;
			cfg_q.data_endpoint      <= 4'd3;
			cfg_q.data_ep_type       <= 2'd3;
			cfg_q.data_ep_max_packet <= 10'd8;
			cfg_q.device_desc_len    <= 8'd18;
			cfg_q.config_desc_len    <= 10'd34;
			cfg_q.hid_report_len     <= 10'd52;
			cfg_q.mouse_report_len   <= 7'd4;
		end else if (wr_en) begin
			case (wr_index)
				usbcs_pkg::CfgEp0MaxPacket:   cfg_q.ep0_max_packet     <= wr_data[6:0];
				usbcs_pkg::CfgDataEndpoint:   cfg_q.data_endpoint      <= wr_data[3:0];
				usbcs_pkg::CfgDataEpType:     cfg_q.data_ep_type       <= wr_data[1:0];
				usbcs_pkg::CfgDataEpMaxPkt:   cfg_q.data_ep_max_packet <= wr_data;
				usbcs_pkg::CfgDeviceDescLen:  cfg_q.device_desc_len    <= wr_data[7:0];
				usbcs_pkg::CfgConfigDescLen:  cfg_q.config_desc_len    <= wr_data;
				usbcs_pkg::CfgHidReportLen:   cfg_q.hid_report_len     <= wr_data;
				usbcs_pkg::CfgMouseReportLen: cfg_q.mouse_report_len   <= wr_data[6:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- design/usbcs_seq.sv -----
// Control transfer state, request decode and result generation for one event.
module usbcs_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  usbcs_pkg::cfg_t     cfg,
	input  usbcs_pkg::item_t    item,
	input  logic                go,
	output usbcs_pkg::result_t  res0,
	output usbcs_pkg::result_t  res1,
	output logic [1:0]          res_cnt
);

	// One-hot control stage.
	typedef enum logic [5:0] {
		STG_SETUP      = 6'b000001,
		STG_DATA_IN    = 6'b000010,
		STG_IDLE       = 6'b000100,
		STG_ZERO       = 6'b001000,
		STG_STATUS_OUT = 6'b010000,
		STG_STATUS_IN  = 6'b100000
	} stage_t;

	stage_t      stage_q, stage_d;
	logic [1:0]  dev_state_q, dev_state_d;
	logic [15:0] remaining_q, remaining_d;
	logic [15:0] offset_q, offset_d;
	logic [1:0]  source_q, source_d;

	logic [6:0]  sel;
	logic [7:0]  dtype;
	logic [15:0] desc_len;
	logic [15:0] send_len;
	logic [6:0]  chunk;
	logic [15:0] remaining_after;
	logic        mouse_hit;
	logic [2:0]  stage_code;

	// Map the one-hot stage to its port code.
	function automatic logic [2:0] stage_encode(input stage_t s);
		logic [2:0] code;
		case (s)
			STG_SETUP:      code = usbcs_pkg::StageSetupCode;
			STG_DATA_IN:    code = usbcs_pkg::StageDataInCode;
			STG_IDLE:       code = usbcs_pkg::StageIdleCode;
			STG_ZERO:       code = usbcs_pkg::StageZeroCode;
			STG_STATUS_OUT: code = usbcs_pkg::StageStatusOutCode;
			STG_STATUS_IN:  code = usbcs_pkg::StageStatusInCode;
			default:        code = usbcs_pkg::StageSetupCode;
		endcase
		return code;
	endfunction

	// Request fields and the descriptor length that a descriptor read would use.
	assign sel   = item.request_type[6:0];
	assign dtype = item.request_value[15:8];

	always_comb begin
		if (sel == usbcs_pkg::SelStdIntf) begin
			desc_len = {6'd0, cfg.hid_report_len};
		end else if (dtype == usbcs_pkg::DescDevice) begin
			desc_len = {8'd0, cfg.device_desc_len};
		end else begin
			desc_len = {6'd0, cfg.config_desc_len};
		end
	end

	// The byte count is clamped to the descriptor length.
	assign send_len = (item.request_length < desc_len) ? item.request_length : desc_len;

	// Next chunk of the descriptor, at most one endpoint 0 packet.
	assign chunk = (remaining_q < {9'd0, cfg.ep0_max_packet}) ? remaining_q[6:0]
		: cfg.ep0_max_packet;
	assign remaining_after = remaining_q - {9'd0, chunk};

	assign mouse_hit = (item.endpoint == cfg.data_endpoint);

	// Decode the event, derive the next state and build the results.
	always_comb begin
		stage_d     = stage_q;
		dev_state_d = dev_state_q;
		remaining_d = remaining_q;
		offset_d    = offset_q;
		source_d    = source_q;
		res0        = '0;
		res1        = '0;
		res_cnt     = 2'd0;
		case (item.kind)
			usbcs_pkg::KindSetup: begin
				if (sel == usbcs_pkg::SelStdDevice) begin
					if (item.request_code == usbcs_pkg::ReqGetDescriptor) begin
						if (dtype == usbcs_pkg::DescDevice || dtype == usbcs_pkg::DescConfig) begin
							source_d    = (dtype == usbcs_pkg::DescDevice) ? usbcs_pkg::SrcDevice
								: usbcs_pkg::SrcConfig;
							offset_d    = '0;
							remaining_d = send_len;
							stage_d     = STG_DATA_IN;
						end
					end else if (item.request_code == usbcs_pkg::ReqSetAddress) begin
						dev_state_d      = usbcs_pkg::DevAddressed;
						stage_d          = STG_STATUS_IN;
						res0.action      = usbcs_pkg::ActSetAddr;
						res0.new_address = item.request_value[6:0];
						res_cnt          = 2'd1;
					end else if (item.request_code == usbcs_pkg::ReqSetConfig) begin
						dev_state_d          = usbcs_pkg::DevConfigured;
						stage_d              = STG_STATUS_IN;
						res0.action          = usbcs_pkg::ActConfigEp;
						res0.packet_endpoint = cfg.data_endpoint;
						res0.packet_length   = cfg.data_ep_max_packet;
						res0.ep_type         = cfg.data_ep_type;
						res1.action          = usbcs_pkg::ActWrite;
						res1.packet_endpoint = cfg.data_endpoint;
						res_cnt              = 2'd2;
					end
				end else if (sel == usbcs_pkg::SelClassIntf) begin
					if (item.request_code == usbcs_pkg::ReqSetIdle) begin
						stage_d = STG_STATUS_IN;
					end
				end else if (sel == usbcs_pkg::SelStdIntf) begin
					if (item.request_code == usbcs_pkg::ReqGetDescriptor
						&& dtype == usbcs_pkg::DescHidReport) begin
						source_d    = usbcs_pkg::SrcHid;
						offset_d    = '0;
						remaining_d = send_len;
						stage_d     = STG_DATA_IN;
					end
				end
			end
			usbcs_pkg::KindPoll: begin
				case (stage_q)
					STG_DATA_IN: begin
						res0.action        = usbcs_pkg::ActWrite;
						res0.data_source   = source_q;
						res0.data_offset   = offset_q;
						res0.packet_length = {3'd0, chunk};
						res_cnt            = 2'd1;
						remaining_d        = remaining_after;
						offset_d           = offset_q + {9'd0, chunk};
						if (remaining_after != '0) begin
							stage_d = STG_IDLE;
						end else if (chunk == cfg.ep0_max_packet) begin
							stage_d = STG_ZERO;
						end else begin
							stage_d = STG_STATUS_OUT;
						end
					end
					STG_STATUS_OUT: begin
						stage_d = STG_SETUP;
					end
					STG_STATUS_IN: begin
						res0.action = usbcs_pkg::ActWrite;
						res_cnt     = 2'd1;
						stage_d     = STG_SETUP;
					end
					default: ;
				endcase
			end
			usbcs_pkg::KindInDone: begin
				if (remaining_q != '0) begin
					stage_d = STG_DATA_IN;
					if (mouse_hit) begin
						res0.action          = usbcs_pkg::ActMouse;
						res0.packet_endpoint = cfg.data_endpoint;
						res0.packet_length   = {3'd0, cfg.mouse_report_len};
						res_cnt              = 2'd1;
					end
				end else if (stage_q == STG_ZERO) begin
					// Zero-length packet closes a data stage whose last chunk was full.
					stage_d     = STG_STATUS_OUT;
					res0.action = usbcs_pkg::ActWrite;
					res_cnt     = 2'd1;
					if (mouse_hit) begin
						res1.action          = usbcs_pkg::ActMouse;
						res1.packet_endpoint = cfg.data_endpoint;
						res1.packet_length   = {3'd0, cfg.mouse_report_len};
						res_cnt              = 2'd2;
					end
				end else if (mouse_hit) begin
					res0.action          = usbcs_pkg::ActMouse;
					res0.packet_endpoint = cfg.data_endpoint;
					res0.packet_length   = {3'd0, cfg.mouse_report_len};
					res_cnt              = 2'd1;
				end
			end
			default: begin
				// Bus reset clears all transfer state and drops the address.
				stage_d     = STG_SETUP;
				dev_state_d = usbcs_pkg::DevDefault;
				remaining_d = '0;
				offset_d    = '0;
				source_d    = usbcs_pkg::SrcNone;
				res0.action = usbcs_pkg::ActSetAddr;
				res_cnt     = 2'd1;
			end
		endcase
		res0.device_state  = dev_state_d;
		res0.control_stage = stage_code;
		res0.last          = (res_cnt == 2'd1);
		res1.device_state  = dev_state_d;
		res1.control_stage = stage_code;
		res1.last          = 1'b1;
	end

	assign stage_code = stage_encode(stage_d);

	// State advances once per processed event.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q     <= STG_SETUP;
			dev_state_q <= usbcs_pkg::DevDefault;
			remaining_q <= '0;
			offset_q    <= '0;
			source_q    <= usbcs_pkg::SrcNone;
		end else if (go) begin
			stage_q     <= stage_d;
			dev_state_q <= dev_state_d;
			remaining_q <= remaining_d;
			offset_q    <= offset_d;
			source_q    <= source_d;
		end
	end

endmodule

// ----- design/usbcs_out_fifo.sv -----
// Result queue that takes up to two results per cycle and hands out one.
module usbcs_out_fifo #(
	parameter int unsigned DEPTH = usbcs_pkg::OutDepthDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_cnt,
	input  usbcs_pkg::result_t  din0,
	input  usbcs_pkg::result_t  din1,
	input  logic                pop,
	output logic                room,
	output logic                out_valid,
	output usbcs_pkg::result_t  dout
);

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	usbcs_pkg::result_t mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PtrW-1:0] wr_ptr_1, wr_ptr_2;
	logic [CntW-1:0] count_q;

	// Pointer increment with wrap at the queue depth.
	function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
		logic [PtrW-1:0] n;
		n = (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
		return n;
	endfunction

	assign wr_ptr_1 = ptr_next(wr_ptr_q);
	assign wr_ptr_2 = ptr_next(wr_ptr_1);

	// Space for two results is required before an event is processed.
	assign room      = (count_q <= CntW'(DEPTH - 2));
	assign out_valid = (count_q != '0);
	assign dout      = mem_q[rd_ptr_q];

	// Result storage.
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= din0;
		end
		if (push_cnt == 2'd2) begin
			mem_q[wr_ptr_1] <= din1;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			case (push_cnt)
				2'd1:    wr_ptr_q <= wr_ptr_1;
				2'd2:    wr_ptr_q <= wr_ptr_2;
				default: ;
			endcase
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			count_q <= count_q + CntW'(push_cnt) - CntW'(pop);
		end
	end

endmodule

// ----- design/usb_control_endpoint_sequencer_core.sv -----
// Top level of the USB control endpoint sequencer.
// Each accepted event is held in an input register and is decoded against the control
// state in the following cycle; its results (none, one or two) then enter a result queue
// of OUT_DEPTH entries, from which they are offered on the output channel. An event is
// processed only when the queue has space for two results, so a new event is taken every
// cycle only while the queue keeps that space; the output port hands out one result per
// cycle while out_ready is high, which makes a two-result event (a configuration select,
// or a zero-length packet plus mouse report) take two handshakes on the output. The
// configuration port is always ready and should be written only while no event is in
// progress.
module usb_control_endpoint_sequencer_core #(
	parameter int unsigned OUT_DEPTH = usbcs_pkg::OutDepthDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	// Event channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [7:0]  request_type,
	input  logic [7:0]  request_code,
	input  logic [15:0] request_value,
	input  logic [15:0] request_length,
	input  logic [3:0]  endpoint,
	// Result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  action,
	output logic [3:0]  packet_endpoint,
	output logic [1:0]  data_source,
	output logic [15:0] data_offset,
	output logic [9:0]  packet_length,
	output logic [6:0]  new_address,
	output logic [1:0]  ep_type,
	output logic [1:0]  device_state,
	output logic [2:0]  control_stage,
	output logic        last,
	// Configuration channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	usbcs_pkg::cfg_t    cfg;
	usbcs_pkg::item_t   item_s1;
	logic               valid_s1;
	logic               go;
	logic               room;
	usbcs_pkg::result_t res0, res1, res_out;
	logic [1:0]         res_cnt;

	assign cfg_ready = 1'b1;

	usbcs_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Input register: refilled whenever the held event is processed or absent.
	assign go       = valid_s1 && room;
	assign in_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.kind           <= kind;
			item_s1.request_type   <= request_type;
			item_s1.request_code   <= request_code;
			item_s1.request_value  <= request_value;
			item_s1.request_length <= request_length;
			item_s1.endpoint       <= endpoint;
		end
	end

	usbcs_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.item    (item_s1),
		.go      (go),
		.res0    (res0),
		.res1    (res1),
		.res_cnt (res_cnt)
	);

	usbcs_out_fifo #(
		.DEPTH (OUT_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (go ? res_cnt : 2'd0),
		.din0      (res0),
		.din1      (res1),
		.pop       (out_valid && out_ready),
		.room      (room),
		.out_valid (out_valid),
		.dout      (res_out)
	);

	// Result fields.
	assign action          = res_out.action;
	assign packet_endpoint = res_out.packet_endpoint;
	assign data_source     = res_out.data_source;
	assign data_offset     = res_out.data_offset;
	assign packet_length   = res_out.packet_length;
	assign new_address     = res_out.new_address;
	assign ep_type         = res_out.ep_type;
	assign device_state    = res_out.device_state;
	assign control_stage   = res_out.control_stage;
	assign last            = res_out.last;

endmodule

// ----- design/usbcs_checker.sv -----
// Port-level checks for the USB control endpoint sequencer, bound to its top level.
module usbcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  action,
	input logic [3:0]  packet_endpoint,
	input logic [15:0] data_offset,
	input logic        last
);

	// A stalled result stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its offset and action.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(data_offset) && $stable(action))
		else $error("result changed while stalled");

	// An endpoint configure transfer is always followed by its zero-length write.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == usbcs_pkg::ActConfigEp |-> !last)
		else $error("configure action marked as final result");

	// A mouse report is always the final result of its event.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == usbcs_pkg::ActMouse |-> last)
		else $error("mouse report not marked as final result");

	// Address changes go to the default pipe only and end their event.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && action == usbcs_pkg::ActSetAddr |-> last && packet_endpoint == 4'd0)
		else $error("set address result malformed");

endmodule

bind usb_control_endpoint_sequencer_core usbcs_checker u_usbcs_checker (.*);
